// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/fp8sdp_pkg.sv =====
// types, constants, decode and leading-zero count functions for the fp8 scaled dot product block
// no dependencies
package fp8sdp_pkg;

   localparam logic [31:0] CANON_NAN   = 32'h7FC0_0000;
   localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;
   localparam int unsigned BF16_SHIFT  = 16;

   typedef struct packed {
      logic [7:0]  weight_code;
      logic [15:0] activation_bf16;
      logic        row_end;
   } req_type;

   typedef struct packed {
      logic [31:0] row_sum_bits;
      logic        status;
   } rsp_type;

   typedef struct packed {
      logic [31:0] weight_f32;
      logic [31:0] act_f32;
      logic        row_end;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_NORM,
      ST_RND
   } state_type;

   typedef enum logic [1:0] {
      PH_SCALE,
      PH_ACT,
      PH_ACCUM
   } phase_type;

   function automatic logic [31:0] fp8_decode(input logic [7:0] code);
      logic       sgn;
      logic [3:0] ex;
      logic [2:0] man;
      logic [7:0] e8;
      logic [22:0] m23;
      sgn = code[7];
      ex  = code[6:3];
      man = code[2:0];
      e8  = 8'd0;
      m23 = 23'd0;
      if (ex == 4'hF && man == 3'd7) begin
         return CANON_NAN | {sgn, 31'd0};
      end
      if (ex == 4'd0) begin
         case (man)
            3'd1: begin e8 = 8'd118; m23 = 23'h000000; end
            3'd2: begin e8 = 8'd119; m23 = 23'h000000; end
            3'd3: begin e8 = 8'd119; m23 = 23'h400000; end
            3'd4: begin e8 = 8'd120; m23 = 23'h000000; end
            3'd5: begin e8 = 8'd120; m23 = 23'h200000; end
            3'd6: begin e8 = 8'd120; m23 = 23'h400000; end
            3'd7: begin e8 = 8'd120; m23 = 23'h600000; end
            default: begin e8 = 8'd0; m23 = 23'd0; end
         endcase
         return {sgn, e8, m23};
      end
      return {sgn, {4'd0, ex} + 8'd120, man, 20'd0};
   endfunction

   function automatic logic [5:0] lzc50(input logic [49:0] w);
      logic [5:0] n;
      n = 6'd0;
      for (int i = 0; i < 50; i++) begin
         if (w[i]) n = 6'(49 - i);
      end
      return n;
   endfunction

endpackage

// ===== design/fp8sdp_front.sv =====
// front end: takes requests, decodes the fp8 weight and widens the bf16 activation
// depends on fp8sdp_pkg
module fp8sdp_front (
   input  logic                req_push,
   output logic                req_full,
   input  fp8sdp_pkg::req_type req_data,
   output logic                q_push,
   input  logic                q_full,
   output fp8sdp_pkg::item_type q_item
);
   import fp8sdp_pkg::*;

   assign req_full = q_full;
   assign q_push   = req_push & ~q_full;

   always_comb begin
      q_item.weight_f32 = fp8_decode(req_data.weight_code);
      q_item.act_f32    = {req_data.activation_bf16, {BF16_SHIFT{1'b0}}};
      q_item.row_end    = req_data.row_end;
   end

endmodule

// ===== design/fp8sdp_queue.sv =====
// short queue of decoded items between front end and back end
// depends on fp8sdp_pkg
module fp8sdp_queue #(
   parameter int Depth = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  fp8sdp_pkg::item_type push_item,
   input  logic                 pop,
   output logic                 valid,
   output fp8sdp_pkg::item_type pop_item
);
   import fp8sdp_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   item_type            entries [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == CntW'(Depth));
   assign valid    = (count_ff != '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & valid;
   assign pop_item = entries[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== design/fp8sdp_back.sv =====
// back end: shared binary32 multiply, add, normalize and round sequencer with accumulator
// depends on fp8sdp_pkg
module fp8sdp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  fp8sdp_pkg::item_type q_item,
   output logic                 q_pop,
   input  logic [31:0]          scale_bits,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output fp8sdp_pkg::rsp_type  rsp_data
);
   import fp8sdp_pkg::*;

   state_type          state_ff, state_in;
   phase_type          phase_ff, phase_in;
   logic [31:0]        opa_ff, opb_ff, act_ff, acc_ff, acc_in;
   logic               last_ff;
   logic               spec_ff;
   logic [31:0]        spec_val_ff;
   logic [49:0]        wide_ff;
   logic signed [10:0] ebase_ff;
   logic               sign_ff;
   logic [47:0]        sig_ff;
   logic signed [10:0] exp_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               load, finish, can_finish;

   // operand fields
   logic [7:0]  ea, eb, eeff_a, eeff_b;
   logic [23:0] siga, sigb;
   logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

   // multiply stage
   logic [47:0]        m_prod;
   logic               m_spec;
   logic [31:0]        m_spec_val;
   logic signed [10:0] m_ebase;

   // add stage
   logic               a_big, s_big, sub, stk;
   logic [7:0]         e_big, d;
   logic [5:0]         dcl;
   logic [23:0]        sig_big, sig_small;
   logic [99:0]        shl;
   logic [49:0]        bigw, thi, ad_w;
   logic               ad_spec;
   logic [31:0]        ad_spec_val;

   // normalize stage
   logic [5:0]         lz;
   logic [49:0]        wn;
   logic [47:0]        n_sig;
   logic signed [10:0] n_exp;

   // round stage
   logic               normal, g, st, up;
   logic signed [10:0] sh_full;
   logic [5:0]         sh;
   logic [95:0]        rsh;
   logic [47:0]        shv;
   logic [23:0]        mant24;
   logic [7:0]         eadj;
   logic [30:0]        base;
   logic [31:0]        res;

   logic               scale_bad;
   logic [31:0]        sum_out;

   always_comb begin
      ea     = opa_ff[30:23];
      eb     = opb_ff[30:23];
      eeff_a = (ea == 8'd0) ? 8'd1 : ea;
      eeff_b = (eb == 8'd0) ? 8'd1 : eb;
      siga   = {ea != 8'd0, opa_ff[22:0]};
      sigb   = {eb != 8'd0, opb_ff[22:0]};
      a_nan  = (ea == 8'hFF) && (opa_ff[22:0] != 23'd0);
      b_nan  = (eb == 8'hFF) && (opb_ff[22:0] != 23'd0);
      a_inf  = (ea == 8'hFF) && (opa_ff[22:0] == 23'd0);
      b_inf  = (eb == 8'hFF) && (opb_ff[22:0] == 23'd0);
      a_zero = (opa_ff[30:0] == 31'd0);
      b_zero = (opb_ff[30:0] == 31'd0);
   end

   always_comb begin
      m_prod     = siga * sigb;
      m_ebase    = $signed({3'd0, eeff_a}) + $signed({3'd0, eeff_b}) - 11'sd124;
      m_spec     = 1'b1;
      m_spec_val = CANON_NAN;
      if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
         m_spec_val = CANON_NAN;
      end else if (a_inf || b_inf) begin
         m_spec_val = {opa_ff[31] ^ opb_ff[31], 8'hFF, 23'd0};
      end else if (a_zero || b_zero) begin
         m_spec_val = {opa_ff[31] ^ opb_ff[31], 31'd0};
      end else begin
         m_spec = 1'b0;
      end
   end

   always_comb begin
      a_big     = (opa_ff[30:0] >= opb_ff[30:0]);
      s_big     = a_big ? opa_ff[31] : opb_ff[31];
      e_big     = a_big ? eeff_a : eeff_b;
      d         = a_big ? (eeff_a - eeff_b) : (eeff_b - eeff_a);
      sig_big   = a_big ? siga : sigb;
      sig_small = a_big ? sigb : siga;
      dcl       = (d > 8'd50) ? 6'd50 : d[5:0];
      shl       = {1'b0, sig_small, 25'd0, 50'd0} >> dcl;
      thi       = shl[99:50];
      stk       = |shl[49:0];
      bigw      = {1'b0, sig_big, 25'd0};
      sub       = opa_ff[31] ^ opb_ff[31];
      if (sub) begin
         ad_w = (bigw - thi - {49'd0, stk}) | {49'd0, stk};
      end else begin
         ad_w = (bigw + thi) | {49'd0, stk};
      end
      ad_spec     = 1'b1;
      ad_spec_val = CANON_NAN;
      if (a_nan || b_nan || (a_inf && b_inf && sub)) begin
         ad_spec_val = CANON_NAN;
      end else if (a_inf) begin
         ad_spec_val = opa_ff;
      end else if (b_inf) begin
         ad_spec_val = opb_ff;
      end else if (ad_w == 50'd0) begin
         ad_spec_val = {opa_ff[31] & opb_ff[31], 31'd0};
      end else begin
         ad_spec = 1'b0;
      end
   end

   always_comb begin
      lz    = lzc50(wide_ff);
      wn    = wide_ff << lz;
      n_sig = wn[49:2] | {47'd0, |wn[1:0]};
      n_exp = ebase_ff - $signed({5'd0, lz});
   end

   always_comb begin
      normal  = (exp_ff >= 11'sd1);
      sh_full = 11'sd1 - exp_ff;
      if (normal) begin
         sh = 6'd0;
      end else if (sh_full > 11'sd48) begin
         sh = 6'd48;
      end else begin
         sh = sh_full[5:0];
      end
      rsh    = {sig_ff, 48'd0} >> sh;
      shv    = rsh[95:48];
      mant24 = shv[47:24];
      g      = shv[23];
      st     = (|shv[22:0]) | (|rsh[47:0]);
      up     = g & (st | mant24[0]);
      eadj   = normal ? (exp_ff[7:0] - 8'd1) : 8'd0;
      base   = {eadj, 23'd0} + {7'd0, mant24} + {30'd0, up};
      if (spec_ff) begin
         res = spec_val_ff;
      end else if (exp_ff >= 11'sd255) begin
         res = {sign_ff, 8'hFF, 23'd0};
      end else begin
         res = {sign_ff, base};
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (q_valid) state_in = ST_MUL;
         ST_MUL:  state_in = ST_NORM;
         ST_ADD:  state_in = ST_NORM;
         ST_NORM: state_in = ST_RND;
         ST_RND: begin
            unique case (phase_ff)
               PH_SCALE: state_in = ST_MUL;
               PH_ACT:   state_in = ST_ADD;
               PH_ACCUM: if (can_finish) state_in = ST_IDLE;
               default:  state_in = ST_IDLE;
            endcase
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      can_finish = ~last_ff | ~rsp_valid_ff | rsp_pop;
      load       = (state_ff == ST_IDLE) && q_valid;
      q_pop      = load;
      finish     = (state_ff == ST_RND) && (phase_ff == PH_ACCUM) && can_finish;
      phase_in   = phase_ff;
      if (load) begin
         phase_in = PH_SCALE;
      end else if (state_ff == ST_RND && phase_ff == PH_SCALE) begin
         phase_in = PH_ACT;
      end else if (state_ff == ST_RND && phase_ff == PH_ACT) begin
         phase_in = PH_ACCUM;
      end
   end

   always_comb begin
      scale_bad = (scale_bits[30:23] == 8'hFF) ||
                  (scale_bits[31] && (scale_bits[30:0] != 31'd0));
      sum_out   = res;
      if (res[30:23] == 8'hFF && res[22:0] != 23'd0) sum_out = CANON_NAN;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_pop;
      rsp_data_in  = rsp_data_ff;
      if (finish) begin
         acc_in = last_ff ? 32'd0 : res;
         if (last_ff) begin
            rsp_valid_in = 1'b1;
            if (scale_bad) begin
               rsp_data_in.row_sum_bits = 32'd0;
               rsp_data_in.status       = 1'b1;
            end else begin
               rsp_data_in.row_sum_bits = sum_out;
               rsp_data_in.status       = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_SCALE;
         acc_ff       <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (load) begin
         opa_ff  <= q_item.weight_f32;
         opb_ff  <= scale_bits;
         act_ff  <= q_item.act_f32;
         last_ff <= q_item.row_end;
      end
      if (state_ff == ST_MUL) begin
         spec_ff     <= m_spec;
         spec_val_ff <= m_spec_val;
         wide_ff     <= {2'd0, m_prod};
         ebase_ff    <= m_ebase;
         sign_ff     <= opa_ff[31] ^ opb_ff[31];
      end
      if (state_ff == ST_ADD) begin
         spec_ff     <= ad_spec;
         spec_val_ff <= ad_spec_val;
         wide_ff     <= ad_w;
         ebase_ff    <= $signed({3'd0, e_big}) + 11'sd1;
         sign_ff     <= s_big;
      end
      if (state_ff == ST_NORM) begin
         sig_ff <= n_sig;
         exp_ff <= n_exp;
      end
      if (state_ff == ST_RND && phase_ff == PH_SCALE) begin
         opa_ff <= res;
         opb_ff <= act_ff;
      end
      if (state_ff == ST_RND && phase_ff == PH_ACT) begin
         opa_ff <= acc_ff;
         opb_ff <= res;
      end
   end

   assign rsp_empty = ~rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/fp8_e4m3_scaled_dot_product.sv =====
// the back end starts a new request only when it is through with the last; the shared
// multiply/add/round unit is held by each request in turn
// and runs two multiplies and one accumulate add per request in sequence
// a two-entry queue lets requests be taken while the back end is busy
// reset (synchronous): empty queues, accumulator +0.0, weight scale 1.0
// depends on fp8sdp_pkg, fp8sdp_front, fp8sdp_queue, fp8sdp_back
module fp8_e4m3_scaled_dot_product #(
   parameter int QueueDepth = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  fp8sdp_pkg::req_type req_data,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output fp8sdp_pkg::rsp_type rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [31:0]         csr_data
);
   import fp8sdp_pkg::*;

   logic [31:0] scale_ff;
   logic        q_push, q_full, q_valid, q_pop;
   item_type    q_in, q_out;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_valid && csr_ready) begin
         scale_ff <= csr_data;
      end
   end

   fp8sdp_front u_front (
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_push   (q_push),
      .q_full   (q_full),
      .q_item   (q_in)
   );

   fp8sdp_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .full      (q_full),
      .push_item (q_in),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_item  (q_out)
   );

   fp8sdp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_out),
      .q_pop      (q_pop),
      .scale_bits (scale_ff),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== design/fp8sdp_checker.sv =====
// port-level checks for the fp8 scaled dot product block, bound to the top level
// depends on fp8sdp_pkg and assert_macros.svh
`include "assert_macros.svh"

module fp8sdp_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_empty,
   input logic                rsp_pop,
   input fp8sdp_pkg::rsp_type rsp_data,
   input logic                csr_ready
);
   import fp8sdp_pkg::*;

   `ASSERT_SAME(a_empty_after_reset, clock, reset, $fell(reset), rsp_empty, "result present after reset")
   `ASSERT_NEXT(a_rsp_held, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty, "result dropped")
   `ASSERT_SAME(a_error_zero, clock, reset, !rsp_empty && rsp_data.status, rsp_data.row_sum_bits == 32'd0, "error with nonzero sum")
   `ASSERT_SAME(a_nan_canon, clock, reset, !rsp_empty && rsp_data.row_sum_bits[30:23] == 8'hFF && rsp_data.row_sum_bits[22:0] != 23'd0, rsp_data.row_sum_bits == CANON_NAN, "nan not canonical")
   `ASSERT_SAME(a_csr_ready, clock, reset, 1'b1, csr_ready, "csr not ready")

endmodule

bind fp8_e4m3_scaled_dot_product fp8sdp_checker u_checker (.*);

// ===== sim/fp8_e4m3_scaled_dot_product_tb.sv =====
// testbench for fp8_e4m3_scaled_dot_product: directed and random rows, binary32 predictor
// built on integer arithmetic, scoreboard on the result queue side
// depends on fp8sdp_pkg and the fp8_e4m3_scaled_dot_product rtl
`timescale 1ns / 1ps

module fp8_e4m3_scaled_dot_product_tb;
   import fp8sdp_pkg::*;

   localparam int unsigned CycleLimit = 600000;
   localparam int unsigned DrainCycles = 40;
   localparam logic [31:0] POS_INF = 32'h7F80_0000;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   req_type     req_data;
   logic        rsp_empty;
   logic        rsp_pop;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_data;

   req_type     pending_req_q[$];
   rsp_type     row_sum_q[$];
   logic [31:0] scale_bits;
   logic [31:0] acc_bits;
   int unsigned cycle_count;
   int unsigned send_gap;
   int unsigned recv_gap;
   int unsigned hold_count;
   bit          no_idle;
   bit          long_hold_req;
   bit          long_hold_done;
   bit          failed;
   bit          sent_last;

   fp8_e4m3_scaled_dot_product uut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // round m * 2^e to binary32, nearest even
   function automatic logic [31:0] f32_round(input bit s, input logic [127:0] m, input int e);
      int          p;
      int          big_e;
      int          lsb;
      int          sh;
      logic [127:0] q;
      logic [127:0] r;
      logic [127:0] half;
      logic [127:0] enc;
      p = 0;
      for (int i = 0; i < 128; i++) if (m[i]) p = i;
      big_e = p + e;
      if (big_e > 127) return {s, POS_INF[30:0]};
      lsb = (big_e < -126) ? -149 : big_e - 23;
      sh = lsb - e;
      if (sh <= 0) begin
         q = m << (-sh);
      end else if (sh > 127) begin
         q = '0;
      end else begin
         q = m >> sh;
         r = m & ((128'd1 << sh) - 128'd1);
         half = 128'd1 << (sh - 1);
         if (r > half || (r == half && q[0])) q = q + 128'd1;
      end
      if (big_e < -126) enc = q;
      else enc = (128'(big_e + 127) << 23) + q - 128'h80_0000;
      if (enc >= 128'h7F80_0000) return {s, POS_INF[30:0]};
      return {s, enc[30:0]};
   endfunction

   function automatic bit f32_is_nan(input logic [31:0] a);
      return a[30:23] == 8'hFF && a[22:0] != 0;
   endfunction

   function automatic bit f32_is_inf(input logic [31:0] a);
      return a[30:0] == POS_INF[30:0];
   endfunction

   function automatic logic [23:0] f32_sig(input logic [31:0] a);
      return (a[30:23] == 0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
   endfunction

   function automatic int f32_exp(input logic [31:0] a);
      return (a[30:23] == 0) ? -149 : int'(a[30:23]) - 150;
   endfunction

   function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
      bit s;
      s = a[31] ^ b[31];
      if (f32_is_nan(a) || f32_is_nan(b)) return CANON_NAN;
      if (f32_is_inf(a) || f32_is_inf(b)) begin
         if (a[30:0] == 0 || b[30:0] == 0) return CANON_NAN;
         return {s, POS_INF[30:0]};
      end
      if (a[30:0] == 0 || b[30:0] == 0) return {s, 31'd0};
      return f32_round(s, 128'(f32_sig(a)) * 128'(f32_sig(b)), f32_exp(a) + f32_exp(b));
   endfunction

   function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b);
      logic [31:0]  x;
      logic [31:0]  y;
      logic [127:0] mx;
      logic [127:0] my;
      int           d;
      int           e;
      if (f32_is_nan(a) || f32_is_nan(b)) return CANON_NAN;
      if (f32_is_inf(a) && f32_is_inf(b)) return (a[31] == b[31]) ? a : CANON_NAN;
      if (f32_is_inf(a)) return a;
      if (f32_is_inf(b)) return b;
      if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
      if (a[30:0] == 0) return b;
      if (b[30:0] == 0) return a;
      if (f32_exp(a) >= f32_exp(b)) begin
         x = a; y = b;
      end else begin
         x = b; y = a;
      end
      d = f32_exp(x) - f32_exp(y);
      // far smaller operand only matters as a sticky contribution
      if (d > 60) begin
         mx = 128'(f32_sig(x)) << 60;
         my = 128'd1;
         e = f32_exp(x) - 60;
      end else begin
         mx = 128'(f32_sig(x)) << d;
         my = 128'(f32_sig(y));
         e = f32_exp(y);
      end
      if (x[31] == y[31]) return f32_round(x[31], mx + my, e);
      if (mx == my) return 32'd0;
      if (mx > my) return f32_round(x[31], mx - my, e);
      return f32_round(y[31], my - mx, e);
   endfunction

   function automatic logic [31:0] e4m3_to_f32(input logic [7:0] code);
      if (code[6:0] == 7'h7F) return CANON_NAN | {code[7], 31'd0};
      if (code[6:3] == 0) begin
         if (code[2:0] == 0) return {code[7], 31'd0};
         return f32_round(code[7], 128'(code[2:0]), -9);
      end
      return {code[7], 4'd0 + 8'(code[6:3]) + 8'd120, code[2:0], 20'd0};
   endfunction

   function automatic bit scale_is_invalid(input logic [31:0] b);
      return b[30:23] == 8'hFF || (b[31] && b[30:0] != 0);
   endfunction

   task automatic accumulate_request(input req_type r);
      logic [31:0] prod;
      logic [31:0] sum;
      rsp_type     res;
      prod = f32_mul(f32_mul(e4m3_to_f32(r.weight_code), scale_bits),
                     {r.activation_bf16, 16'd0});
      sum = f32_add(acc_bits, prod);
      if (r.row_end) begin
         if (scale_is_invalid(scale_bits)) begin
            res.row_sum_bits = '0;
            res.status = 1'b1;
         end else begin
            res.row_sum_bits = f32_is_nan(sum) ? CANON_NAN : sum;
            res.status = 1'b0;
         end
         row_sum_q.push_back(res);
         acc_bits <= 32'd0;
      end else begin
         acc_bits <= sum;
      end
   endtask

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [15:0] pick_act();
      if ($urandom_range(0, 9) < 7)
         return {1'($urandom), 8'($urandom_range(112, 142)), 7'($urandom)};
      return 16'($urandom);
   endfunction

   // acceptance, prediction and result checking
   always @(posedge clock) begin
      if (reset) begin
         scale_bits <= SCALE_RESET;
         acc_bits <= 32'd0;
         cycle_count <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (cycle_count > CycleLimit) begin
            $display("CHECK FAILED");
            $finish;
         end
         sent_last <= req_push && !req_full;
         if (csr_valid && csr_ready) scale_bits <= csr_data;
         if (req_push && !req_full) begin
            accumulate_request(req_data);
            void'(pending_req_q.pop_front());
         end
         if (rsp_pop && !rsp_empty) begin
            if (row_sum_q.size() == 0) begin
               $error("unexpected result: row_sum_bits %h status %0d",
                      rsp_data.row_sum_bits, rsp_data.status);
               failed = 1'b1;
            end else begin
               if (rsp_data.row_sum_bits !== row_sum_q[0].row_sum_bits) begin
                  $error("row_sum_bits expected %h actual %h",
                         row_sum_q[0].row_sum_bits, rsp_data.row_sum_bits);
                  failed = 1'b1;
               end
               if (rsp_data.status !== row_sum_q[0].status) begin
                  $error("status expected %0d actual %0d",
                         row_sum_q[0].status, rsp_data.status);
                  failed = 1'b1;
               end
               void'(row_sum_q.pop_front());
            end
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         send_gap <= 0;
      end else if (sent_last && !no_idle && send_gap == 0 && pick_gap() != 0) begin
         send_gap <= pick_gap();
         req_push <= 1'b0;
      end else if (send_gap > 0) begin
         send_gap <= send_gap - 1;
         req_push <= 1'b0;
      end else if (pending_req_q.size() > 0) begin
         req_push <= 1'b1;
         req_data <= pending_req_q[0];
      end else begin
         req_push <= 1'b0;
      end
   end

   // result receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         recv_gap <= 0;
         hold_count <= 0;
      end else if (long_hold_req && !long_hold_done) begin
         long_hold_done <= 1'b1;
         hold_count <= 400;
         rsp_pop <= 1'b0;
      end else if (hold_count > 0) begin
         hold_count <= hold_count - 1;
         rsp_pop <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap <= recv_gap - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
         if (!no_idle) recv_gap <= pick_gap();
      end
   end

   task automatic add_request(input logic [7:0] w, input logic [15:0] a, input bit last);
      req_type r;
      r.weight_code = w;
      r.activation_bf16 = a;
      r.row_end = last;
      pending_req_q.push_back(r);
   endtask

   task automatic wait_idle();
      while (pending_req_q.size() > 0 || row_sum_q.size() > 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_scale(input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic add_random_rows(input int unsigned count);
      int unsigned n;
      int unsigned len;
      logic [7:0]  w;
      n = 0;
      while (n < count) begin
         len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, 16);
         for (int unsigned i = 0; i < len; i++) begin
            w = 8'($urandom);
            if ($urandom_range(0, 19) == 0) w = {w[7], 7'h7F};
            add_request(w, pick_act(), i == len - 1);
         end
         n = n + len;
      end
   endtask

   logic [31:0] scale_set[12];

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      rsp_pop = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      no_idle = 1'b0;
      long_hold_req = 1'b0;
      long_hold_done = 1'b0;
      failed = 1'b0;
      sent_last = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // weight extremes, nan and subnormal codes, activation extremes
      add_request(8'h00, 16'h3F80, 1'b1);
      add_request(8'h80, 16'h3F80, 1'b1);
      add_request(8'h7F, 16'h3F80, 1'b1);
      add_request(8'hFF, 16'h0000, 1'b1);
      add_request(8'h7E, 16'h7F7F, 1'b0);
      add_request(8'h7E, 16'h7F7F, 1'b1);
      add_request(8'hFE, 16'h7F80, 1'b1);
      add_request(8'h01, 16'h0001, 1'b1);
      add_request(8'h07, 16'h8001, 1'b0);
      add_request(8'h87, 16'h3F80, 1'b0);
      add_request(8'h08, 16'h7F80, 1'b0);
      add_request(8'h88, 16'h7F80, 1'b1);
      add_request(8'h78, 16'hFFFF, 1'b1);
      add_request(8'h38, 16'h7FC0, 1'b1);
      add_request(8'h00, 16'h7F80, 1'b1);
      add_request(8'h38, 16'h3F80, 1'b0);
      add_request(8'hB8, 16'h3F80, 1'b1);
      add_request(8'h80, 16'h8000, 1'b1);
      wait_idle();

      scale_set = '{32'h0000_0000, 32'h8000_0000, 32'h7F7F_FFFF, 32'h0000_0001,
                    32'h7FC0_0000, 32'h7F80_0000, 32'hBF80_0000, 32'h3C00_0000,
                    32'hFFFF_FFFF, 32'h4B00_0000, 32'h3F80_0000, 32'h3A80_0000};
      for (int k = 0; k < 12; k++) begin
         write_scale(scale_set[k]);
         no_idle = (k % 4 == 2);
         if (k == 3) long_hold_req = 1'b1;
         add_random_rows(90);
         wait_idle();
      end
      for (int k = 0; k < 8; k++) begin
         write_scale((k % 2 == 0) ? {2'b00, 30'($urandom)} : 32'($urandom));
         no_idle = (k == 5);
         add_random_rows(90);
         wait_idle();
      end
      if (!failed) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/fp8sdp_pkg.sv
design/fp8sdp_front.sv
design/fp8sdp_queue.sv
design/fp8sdp_back.sv
design/fp8_e4m3_scaled_dot_product.sv
design/fp8sdp_checker.sv
sim/fp8_e4m3_scaled_dot_product_tb.sv
